>>> rtl/assert_macros.svh
// assertion macros shared by the receiver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> rtl/hcdr_pkg.sv
// shared types and constants for the header checked download receiver
`timescale 1ns / 1ps
`default_nettype none
package hcdr_pkg;
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_REJECT      = 3'd1;
  localparam logic [2:0] ST_HDR_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_PAY_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_CRC_BAD     = 3'd4;

  localparam logic [1:0] REG_SIZE     = 2'd0;
  localparam logic [1:0] REG_CRC      = 2'd1;
  localparam logic [1:0] REG_HDR_TO   = 2'd2;
  localparam logic [1:0] REG_IDLE_TO  = 2'd3;

  localparam logic [3:0] HS_ONE      = 4'd6;
  localparam logic [3:0] HS_DEC_WS   = 4'd7;
  localparam logic [3:0] HS_DEC_SIGN = 4'd8;
  localparam logic [3:0] HS_DEC      = 4'd9;
  localparam logic [3:0] HS_HEX_WS   = 4'd10;
  localparam logic [3:0] HS_HEX_SIGN = 4'd11;
  localparam logic [3:0] HS_HEX      = 4'd12;
  localparam logic [3:0] HS_HEX_PFX  = 4'd13;
  localparam logic [3:0] HS_MATCHED  = 4'd14;
  localparam logic [3:0] HS_FAIL     = 4'd15;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] SAT32    = 32'hFFFFFFFF;
  localparam logic [20:0] MIN_SIZE = 21'd64;

  // queued transaction from front to back
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } item_t;

  // result transaction
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [20:0] payload_offset;
    logic [2:0]  status;
  } result_t;

  // magic prefix characters
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    case (idx)
      3'd0: magic_char = 8'h4D;
      3'd1: magic_char = 8'h43;
      3'd2: magic_char = 8'h46;
      3'd3: magic_char = 8'h4F;
      3'd4: magic_char = 8'h4E;
      3'd5: magic_char = 8'h54;
      default: magic_char = 8'h00;
    endcase
  endfunction

  // bytewise reflected crc update
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    crc_byte = c;
  endfunction
endpackage
`default_nettype wire

>>> rtl/header_checked_download_receiver_core.sv
// top level: config registers, input queue and protocol engine
// a result is registered at the edge its transaction leaves the queue; an accepted
// transaction is held in a queue entry, then in the output register until taken
// throughput: one transaction per cycle unless output stalls; combinational crc and digit step
// a two-entry queue parts input from the engine; an output register parts the engine
// reset: synchronous active-low rst_n clears control state and loads register defaults
`timescale 1ns / 1ps
`default_nettype none
module header_checked_download_receiver_core #(
  parameter int LINE_CAPACITY = 64,
  parameter int MAX_BYTES     = 1572864
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_payload_byte,
  output logic [20:0]      out_payload_offset,
  output logic [2:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  logic [20:0] size_r;
  logic [31:0] crc_r;
  logic [15:0] hto_r, ito_r;
  logic        q_valid, q_ready;
  hcdr_pkg::item_t   q_item;
  hcdr_pkg::result_t res;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 21'd64; crc_r <= 32'd0; hto_r <= 16'd1500; ito_r <= 16'd2000;
    end else if (cfg_valid) begin
      case (cfg_index)
        hcdr_pkg::REG_SIZE:    size_r <= cfg_data[20:0];
        hcdr_pkg::REG_CRC:     crc_r  <= cfg_data;
        hcdr_pkg::REG_HDR_TO:  hto_r  <= cfg_data[15:0];
        hcdr_pkg::REG_IDLE_TO: ito_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  hcdr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_op(in_op), .in_rx_byte(in_rx_byte),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  hcdr_back #(.LINE_CAPACITY(LINE_CAPACITY), .MAX_BYTES(MAX_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .expected_size(size_r), .crc_target(crc_r), .header_timeout(hto_r),
    .idle_timeout(ito_r), .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
  );

  assign out_kind           = res.kind;
  assign out_payload_byte   = res.payload_byte;
  assign out_payload_offset = res.payload_offset;
  assign out_status         = res.status;
endmodule
`default_nettype wire

>>> rtl/hcdr_front.sv
// input stage: accepts transactions and queues them for the engine
`timescale 1ns / 1ps
`default_nettype none
module hcdr_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_op,
  input  wire logic [7:0]       in_rx_byte,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output hcdr_pkg::item_t       q_item
);
  // two-entry queue
  hcdr_pkg::item_t mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       push, pop;

  // every op is queued, even op 3 collects a pending status
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
    rd_nxt  = pop ? ~rd_r : rd_r;
    wr_nxt  = push ? ~wr_r : wr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r].op      <= in_op;
      mem_r[wr_r].rx_byte <= in_rx_byte;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_overflow, clk, rst_n, cnt_r == 2'd2, !push || pop)
  `ASSERT_IMPL(a_no_underflow, clk, rst_n, cnt_r == 2'd0, !pop)
  `ASSERT_NEXT(a_cnt_step, clk, rst_n, push && !pop, cnt_r != 2'd0)
endmodule
`default_nettype wire

>>> rtl/hcdr_back.sv
// protocol engine: header parse, payload crc, status, output register
`timescale 1ns / 1ps
`default_nettype none
module hcdr_back #(
  parameter int LINE_CAPACITY = 64,
  parameter int MAX_BYTES     = 1572864
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire hcdr_pkg::item_t q_item,
  input  wire logic [20:0] expected_size,
  input  wire logic [31:0] crc_target,
  input  wire logic [15:0] header_timeout,
  input  wire logic [15:0] idle_timeout,
  output logic             out_valid,
  input  wire logic        out_ready,
  output hcdr_pkg::result_t out_res
);
  localparam int LW = $clog2(LINE_CAPACITY + 1);
  localparam logic [LW-1:0] LCAP = LW'(LINE_CAPACITY);
  localparam logic [31:0] MAXB = 32'(MAX_BYTES);

  logic [1:0]  phase_r, phase_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [3:0]  hs_r, hs_nxt;
  logic [31:0] sacc_r, sacc_nxt;
  logic [31:0] cacc_r, cacc_nxt;
  logic [3:0]  dcnt_r, dcnt_nxt;
  logic [31:0] rcrc_r, rcrc_nxt;
  logic [20:0] nbytes_r, nbytes_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic        ov_r, ov_nxt;
  hcdr_pkg::result_t res_r, res_nxt;

  logic        take, emit;
  logic [7:0]  c;
  logic        is_dec, is_hex, is_sp;
  logic [3:0]  hv;
  logic [35:0] dec_prod, hex_prod;
  logic [31:0] dec_sat, hex_sat;
  logic [15:0] ticks_inc;
  logic        hdr_ok;

  assign q_ready   = !ov_r || out_ready;
  assign take      = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign c         = q_item.rx_byte;

  // character classes
  always_comb begin
    is_dec = (c >= 8'h30) && (c <= 8'h39);
    is_sp  = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
    is_hex = 1'b1;
    hv     = 4'd0;
    if (is_dec) hv = c[3:0];
    else if ((c >= 8'h61) && (c <= 8'h66)) hv = 4'(c - 8'h57);
    else if ((c >= 8'h41) && (c <= 8'h46)) hv = 4'(c - 8'h37);
    else is_hex = 1'b0;
  end

  // saturating accumulators
  always_comb begin
    dec_prod = {4'd0, sacc_r} * 36'd10 + {32'd0, c[3:0]};
    dec_sat  = (dec_prod[35:32] != 4'd0) ? hcdr_pkg::SAT32 : dec_prod[31:0];
    hex_prod = {cacc_r, 4'd0} + {32'd0, hv};
    hex_sat  = (hex_prod[35:32] != 4'd0) ? hcdr_pkg::SAT32 : hex_prod[31:0];
    ticks_inc = (ticks_r != 16'hFFFF) ? ticks_r + 16'd1 : ticks_r;
    hdr_ok = ((hs_r == hcdr_pkg::HS_HEX) || (hs_r == hcdr_pkg::HS_HEX_PFX) ||
              (hs_r == hcdr_pkg::HS_MATCHED)) &&
             (sacc_r >= {11'd0, hcdr_pkg::MIN_SIZE}) && (sacc_r <= MAXB) &&
             (sacc_r == {11'd0, expected_size}) && (cacc_r == crc_target);
  end

  // main transition
  always_comb begin
    logic [3:0] hs;
    logic       hexpart;
    phase_nxt = phase_r; len_nxt = len_r; hs_nxt = hs_r; sacc_nxt = sacc_r;
    cacc_nxt = cacc_r; dcnt_nxt = dcnt_r; rcrc_nxt = rcrc_r;
    nbytes_nxt = nbytes_r; ticks_nxt = ticks_r;
    emit = 1'b0; res_nxt = '0;
    hs = hs_r; hexpart = 1'b0;
    if (take) begin
      if (phase_r == hcdr_pkg::PH_DONE) begin
        emit = 1'b1;
        res_nxt.kind = 1'b1;
        res_nxt.status = (~rcrc_r == crc_target) ? hcdr_pkg::ST_OK : hcdr_pkg::ST_CRC_BAD;
        phase_nxt = hcdr_pkg::PH_IDLE;
      end
      if (q_item.op == hcdr_pkg::OP_START) begin
        phase_nxt = hcdr_pkg::PH_HEADER; len_nxt = '0; hs_nxt = 4'd0;
        sacc_nxt = '0; cacc_nxt = '0; dcnt_nxt = '0; rcrc_nxt = hcdr_pkg::SAT32;
        nbytes_nxt = '0; ticks_nxt = '0;
      end else if (phase_r == hcdr_pkg::PH_DONE) begin
        // item consumed by the pending status
      end else if (q_item.op == hcdr_pkg::OP_TICK) begin
        if (phase_r == hcdr_pkg::PH_HEADER || phase_r == hcdr_pkg::PH_PAYLOAD) begin
          ticks_nxt = ticks_inc;
          if (ticks_inc >= ((phase_r == hcdr_pkg::PH_HEADER) ? header_timeout
                                                               : idle_timeout)) begin
            emit = 1'b1;
            res_nxt.kind = 1'b1;
            res_nxt.status = (phase_r == hcdr_pkg::PH_HEADER) ? hcdr_pkg::ST_HDR_TIMEOUT
                                                              : hcdr_pkg::ST_PAY_TIMEOUT;
            phase_nxt = hcdr_pkg::PH_IDLE;
          end
        end
      end else if (q_item.op == hcdr_pkg::OP_BYTE) begin
        if (phase_r == hcdr_pkg::PH_HEADER) begin
          if (c == 8'h0A) begin
            if (!hdr_ok) begin
              emit = 1'b1;
              res_nxt.kind = 1'b1;
              res_nxt.status = hcdr_pkg::ST_REJECT;
              phase_nxt = hcdr_pkg::PH_IDLE;
            end else begin
              phase_nxt = hcdr_pkg::PH_PAYLOAD; ticks_nxt = '0;
              rcrc_nxt = hcdr_pkg::SAT32; nbytes_nxt = '0;
            end
          end else if (c != 8'h0D && (len_r + LW'(1)) < LCAP) begin
            len_nxt = len_r + LW'(1);
            // header character parser
            if (c == 8'h00) begin
              hs_nxt = ((hs_r == hcdr_pkg::HS_HEX) || (hs_r == hcdr_pkg::HS_HEX_PFX) ||
                        (hs_r == hcdr_pkg::HS_MATCHED)) ? hcdr_pkg::HS_MATCHED
                                                         : hcdr_pkg::HS_FAIL;
            end else begin
              if (hs_r < hcdr_pkg::HS_ONE) begin
                hs_nxt = (c == hcdr_pkg::magic_char(hs_r[2:0])) ? hs_r + 4'd1
                                                                 : hcdr_pkg::HS_FAIL;
              end else if (hs_r == hcdr_pkg::HS_ONE) begin
                if (c == 8'h31) hs_nxt = hcdr_pkg::HS_DEC_WS;
                else if (!is_sp) hs_nxt = hcdr_pkg::HS_FAIL;
              end else if (hs_r == hcdr_pkg::HS_DEC_WS) begin
                if (is_sp) hs_nxt = hs_r;
                else if (c == 8'h2B) hs_nxt = hcdr_pkg::HS_DEC_SIGN;
                else if (is_dec) begin sacc_nxt = dec_sat; hs_nxt = hcdr_pkg::HS_DEC; end
                else hs_nxt = hcdr_pkg::HS_FAIL;
              end else if (hs_r == hcdr_pkg::HS_DEC_SIGN) begin
                if (is_dec) begin sacc_nxt = dec_sat; hs_nxt = hcdr_pkg::HS_DEC; end
                else hs_nxt = hcdr_pkg::HS_FAIL;
              end else if (hs_r == hcdr_pkg::HS_DEC) begin
                if (is_dec) sacc_nxt = dec_sat;
                else begin hs = hcdr_pkg::HS_HEX_WS; hs_nxt = hs; hexpart = 1'b1; end
              end else if (hs_r == hcdr_pkg::HS_HEX_WS) begin
                hexpart = 1'b1;
              end else if (hs_r == hcdr_pkg::HS_HEX_SIGN) begin
                if (is_hex) begin
                  cacc_nxt = hex_sat; hs_nxt = hcdr_pkg::HS_HEX;
                  if (dcnt_r < 4'd15) dcnt_nxt = dcnt_r + 4'd1;
                end else hs_nxt = hcdr_pkg::HS_FAIL;
              end else if (hs_r == hcdr_pkg::HS_HEX) begin
                if (is_hex) begin
                  cacc_nxt = hex_sat;
                  if (dcnt_r < 4'd15) dcnt_nxt = dcnt_r + 4'd1;
                end else if ((c == 8'h78 || c == 8'h58) && dcnt_r == 4'd1 && cacc_r == 32'd0)
                  hs_nxt = hcdr_pkg::HS_HEX_PFX;
                else hs_nxt = hcdr_pkg::HS_MATCHED;
              end else if (hs_r == hcdr_pkg::HS_HEX_PFX) begin
                if (is_hex) begin
                  cacc_nxt = hex_sat;
                  if (dcnt_r < 4'd15) dcnt_nxt = dcnt_r + 4'd1;
                end else hs_nxt = hcdr_pkg::HS_MATCHED;
              end
              // hex part start, shared by the decimal fall through
              if (hexpart) begin
                if (is_sp) hs_nxt = hcdr_pkg::HS_HEX_WS;
                else if (c == 8'h2B) hs_nxt = hcdr_pkg::HS_HEX_SIGN;
                else if (is_hex) begin
                  cacc_nxt = hex_sat; hs_nxt = hcdr_pkg::HS_HEX;
                  if (dcnt_r < 4'd15) dcnt_nxt = dcnt_r + 4'd1;
                end else hs_nxt = hcdr_pkg::HS_FAIL;
              end
            end
          end
        end else if (phase_r == hcdr_pkg::PH_PAYLOAD) begin
          emit = 1'b1;
          res_nxt.kind = 1'b0;
          res_nxt.payload_byte = c;
          res_nxt.payload_offset = nbytes_r;
          rcrc_nxt = hcdr_pkg::crc_byte(rcrc_r, c);
          nbytes_nxt = nbytes_r + 21'd1;
          ticks_nxt = '0;
          if ((nbytes_r + 21'd1) >= expected_size) phase_nxt = hcdr_pkg::PH_DONE;
        end
      end
    end
    ov_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcdr_pkg::PH_IDLE; len_r <= '0; hs_r <= '0; sacc_r <= '0;
      cacc_r <= '0; dcnt_r <= '0; rcrc_r <= hcdr_pkg::SAT32; nbytes_r <= '0;
      ticks_r <= '0; ov_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; len_r <= len_nxt; hs_r <= hs_nxt; sacc_r <= sacc_nxt;
      cacc_r <= cacc_nxt; dcnt_r <= dcnt_nxt; rcrc_r <= rcrc_nxt; nbytes_r <= nbytes_nxt;
      ticks_r <= ticks_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res_r <= res_nxt;
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_stall_no_take, clk, rst_n, out_valid && !out_ready, !take)
  `ASSERT_IMPL(a_line_bound, clk, rst_n, 1'b1, len_r < LCAP)
  `ASSERT_NEXT(a_done_status, clk, rst_n, take && phase_r == hcdr_pkg::PH_DONE,
               out_valid && out_res.kind)
endmodule
`default_nettype wire

>>> tb/sv/tb_top.sv
// testbench for the header checked download receiver: stimulus, prediction and checking
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  localparam int LINE_CAP = 64;
  localparam int MAX_SIZE = 1572864;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam string MAGIC = "MCFONT";

  // download flavors for the random part
  typedef enum int {
    V_GOOD, V_CRC_BAD, V_CORRUPT, V_ZERO, V_LONG, V_SAT,
    V_SIZE_MISMATCH, V_HDR_TIMEOUT, V_PAY_TIMEOUT, V_ABANDON
  } flavor_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = hcdr_pkg::OP_BYTE;
  logic [7:0] in_rx_byte = 8'd0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_kind;
  logic [7:0] out_payload_byte;
  logic [20:0] out_payload_offset;
  logic [2:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = hcdr_pkg::REG_SIZE;
  logic [31:0] cfg_data = 32'd0;

  header_checked_download_receiver_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_payload_byte(out_payload_byte), .out_payload_offset(out_payload_offset),
    .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // shared run state
  hcdr_pkg::result_t expected_results[$];
  int mismatches = 0;
  int items_sent = 0;
  int stall_cycles = 0;
  bit steady = 1'b0;

  // mirrored registers
  logic [20:0] size_reg;
  logic [31:0] crc_reg;
  logic [15:0] hdr_limit;
  logic [15:0] idle_limit;

  // mirrored receiver state
  logic [1:0] dl_phase;
  int line_len;
  logic [3:0] hdr_step;
  logic [31:0] size_acc;
  logic [31:0] crc_acc;
  logic [3:0] hex_digits;
  logic [31:0] run_crc;
  logic [20:0] byte_count;
  logic [15:0] tick_cnt;

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
    return c;
  endfunction

  function automatic logic [31:0] sat_mac(input logic [31:0] acc, input int unsigned base,
                                          input int unsigned d);
    logic [63:0] v;
    v = {32'd0, acc} * 64'(base) + 64'(d);
    return (v > 64'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C;
  endfunction

  task automatic open_download();
    dl_phase = hcdr_pkg::PH_HEADER;
    line_len = 0;
    hdr_step = 4'd0;
    size_acc = 32'd0;
    crc_acc = 32'd0;
    hex_digits = 4'd0;
    run_crc = hcdr_pkg::SAT32;
    byte_count = 21'd0;
    tick_cnt = 16'd0;
  endtask

  task automatic push_status(input logic [2:0] st);
    hcdr_pkg::result_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    expected_results.push_back(r);
    dl_phase = hcdr_pkg::PH_IDLE;
  endtask

  task automatic take_hex(input int h);
    crc_acc = sat_mac(crc_acc, 16, h);
    if (hex_digits < 4'd15) hex_digits++;
  endtask

  // header text matcher, one kept character at a time
  task automatic match_char(input logic [7:0] c);
    int h;
    bit dec;
    h = hex_val(c);
    dec = (c >= "0" && c <= "9");
    if (c == 8'h00) begin
      hdr_step = (hdr_step == hcdr_pkg::HS_HEX || hdr_step == hcdr_pkg::HS_HEX_PFX ||
                  hdr_step == hcdr_pkg::HS_MATCHED) ? hcdr_pkg::HS_MATCHED
                                                    : hcdr_pkg::HS_FAIL;
      return;
    end
    if (hdr_step < hcdr_pkg::HS_ONE) begin
      hdr_step = (c == MAGIC[hdr_step]) ? hdr_step + 4'd1 : hcdr_pkg::HS_FAIL;
      return;
    end
    case (hdr_step)
      hcdr_pkg::HS_ONE: begin
        if (c == "1") hdr_step = hcdr_pkg::HS_DEC_WS;
        else if (!is_ws(c)) hdr_step = hcdr_pkg::HS_FAIL;
      end
      hcdr_pkg::HS_DEC_WS, hcdr_pkg::HS_DEC_SIGN: begin
        if (dec) begin
          size_acc = sat_mac(size_acc, 10, int'(c) - 48);
          hdr_step = hcdr_pkg::HS_DEC;
        end else if (hdr_step == hcdr_pkg::HS_DEC_WS && is_ws(c)) begin
          hdr_step = hcdr_pkg::HS_DEC_WS;
        end else if (hdr_step == hcdr_pkg::HS_DEC_WS && c == "+") begin
          hdr_step = hcdr_pkg::HS_DEC_SIGN;
        end else begin
          hdr_step = hcdr_pkg::HS_FAIL;
        end
      end
      hcdr_pkg::HS_DEC, hcdr_pkg::HS_HEX_WS: begin
        if (hdr_step == hcdr_pkg::HS_DEC && dec) begin
          size_acc = sat_mac(size_acc, 10, int'(c) - 48);
        end else begin
          // a non-digit after the size starts the hex part
          hdr_step = hcdr_pkg::HS_HEX_WS;
          if (!is_ws(c)) begin
            if (c == "+") hdr_step = hcdr_pkg::HS_HEX_SIGN;
            else if (h >= 0) begin
              take_hex(h);
              hdr_step = hcdr_pkg::HS_HEX;
            end else hdr_step = hcdr_pkg::HS_FAIL;
          end
        end
      end
      hcdr_pkg::HS_HEX_SIGN: begin
        if (h >= 0) begin
          take_hex(h);
          hdr_step = hcdr_pkg::HS_HEX;
        end else hdr_step = hcdr_pkg::HS_FAIL;
      end
      hcdr_pkg::HS_HEX: begin
        if (h >= 0) take_hex(h);
        else if ((c == "x" || c == "X") && hex_digits == 4'd1 && crc_acc == 32'd0)
          hdr_step = hcdr_pkg::HS_HEX_PFX;
        else hdr_step = hcdr_pkg::HS_MATCHED;
      end
      hcdr_pkg::HS_HEX_PFX: begin
        if (h >= 0) take_hex(h);
        else hdr_step = hcdr_pkg::HS_MATCHED;
      end
      default: ;
    endcase
  endtask

  // expected results of one accepted transaction
  task automatic predict_item(input logic [1:0] op, input logic [7:0] b);
    hcdr_pkg::result_t r;
    bit ok;
    if (dl_phase == hcdr_pkg::PH_DONE) begin
      push_status((~run_crc == crc_reg) ? hcdr_pkg::ST_OK : hcdr_pkg::ST_CRC_BAD);
      if (op == hcdr_pkg::OP_START) open_download();
      return;
    end
    if (op == hcdr_pkg::OP_START) begin
      open_download();
      return;
    end
    if (op == hcdr_pkg::OP_TICK) begin
      if (dl_phase == hcdr_pkg::PH_HEADER || dl_phase == hcdr_pkg::PH_PAYLOAD) begin
        if (tick_cnt < 16'hFFFF) tick_cnt++;
        if (dl_phase == hcdr_pkg::PH_HEADER && tick_cnt >= hdr_limit)
          push_status(hcdr_pkg::ST_HDR_TIMEOUT);
        else if (dl_phase == hcdr_pkg::PH_PAYLOAD && tick_cnt >= idle_limit)
          push_status(hcdr_pkg::ST_PAY_TIMEOUT);
      end
      return;
    end
    if (op != hcdr_pkg::OP_BYTE) return;
    if (dl_phase == hcdr_pkg::PH_HEADER) begin
      if (b == 8'h0A) begin
        ok = (hdr_step == hcdr_pkg::HS_HEX || hdr_step == hcdr_pkg::HS_HEX_PFX ||
              hdr_step == hcdr_pkg::HS_MATCHED) &&
             size_acc >= 32'd64 && size_acc <= 32'(MAX_SIZE) &&
             size_acc == {11'd0, size_reg} && crc_acc == crc_reg;
        if (!ok) push_status(hcdr_pkg::ST_REJECT);
        else begin
          dl_phase = hcdr_pkg::PH_PAYLOAD;
          tick_cnt = 16'd0;
          run_crc = hcdr_pkg::SAT32;
          byte_count = 21'd0;
        end
      end else if (b != 8'h0D && line_len + 1 < LINE_CAP) begin
        line_len++;
        match_char(b);
      end
    end else if (dl_phase == hcdr_pkg::PH_PAYLOAD) begin
      r = '0;
      r.kind = KIND_BYTE;
      r.payload_byte = b;
      r.payload_offset = byte_count;
      expected_results.push_back(r);
      run_crc = crc_step(run_crc, b);
      byte_count = byte_count + 21'd1;
      tick_cnt = 16'd0;
      if (byte_count >= size_reg) dl_phase = hcdr_pkg::PH_DONE;
    end
  endtask

  // send one transaction, outside steady mode sometimes with random idle cycles ahead of it
  task automatic send_item(input logic [1:0] op, input logic [7:0] b);
    if (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    predict_item(op, b);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(hcdr_pkg::OP_BYTE, s[i]);
  endtask

  // hold input until every expected result is back and the pipeline is empty
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      hcdr_pkg::REG_SIZE: size_reg = data[20:0];
      hcdr_pkg::REG_CRC: crc_reg = data;
      hcdr_pkg::REG_HDR_TO: hdr_limit = data[15:0];
      hcdr_pkg::REG_IDLE_TO: idle_limit = data[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [20:0] sz, input logic [31:0] crc,
                           input logic [15:0] hto, input logic [15:0] ito);
    drain();
    write_reg(hcdr_pkg::REG_SIZE, {11'd0, sz});
    write_reg(hcdr_pkg::REG_CRC, crc);
    write_reg(hcdr_pkg::REG_HDR_TO, {16'd0, hto});
    write_reg(hcdr_pkg::REG_IDLE_TO, {16'd0, ito});
    cfg_valid <= 1'b0;
  endtask

  function automatic string rand_ws(input int lo, input int hi);
    string s;
    byte ws_chars[4] = '{8'h20, 8'h09, 8'h0B, 8'h0C};
    s = "";
    repeat ($urandom_range(lo, hi)) s = {s, string'(ws_chars[$urandom_range(3)])};
    return s;
  endfunction

  // header line text for one download
  function automatic string header_line(input int sz, input logic [31:0] crc, input flavor_t fl);
    string s, num, pad;
    int pos;
    num = (fl == V_SAT) ? "99999999999" : $sformatf("%0d", sz);
    if (fl == V_SIZE_MISMATCH) num = $sformatf("%0d", sz + $urandom_range(1, 5));
    s = {MAGIC, rand_ws(0, 2), "1", rand_ws(1, 2), ($urandom_range(4) == 0) ? "+" : "", num,
         rand_ws(1, 2), ($urandom_range(5) == 0) ? "+" : ""};
    if ($urandom_range(2) == 0) s = {s, ($urandom_range(1) == 0) ? "0x" : "0X"};
    num = $sformatf("%0h", crc);
    if ($urandom_range(1) == 0) num = num.toupper();
    s = {s, num};
    if ($urandom_range(4) == 0) s = {s, " v2"};
    pos = $urandom_range(s.len() - 1);
    case (fl)
      V_CORRUPT: s[pos] = 8'($urandom_range(255));
      V_ZERO: s = {s.substr(0, pos - 1), string'(8'h00), s.substr(pos, s.len() - 1)};
      V_LONG: begin
        pad = "";
        repeat (60) pad = {pad, string'(8'($urandom_range(33, 126)))};
        s = {s.substr(0, pos - 1), pad, s.substr(pos, s.len() - 1)};
      end
      default: ;
    endcase
    if ($urandom_range(2) == 0) s = {s, string'(8'h0D)};
    return {s, string'(8'h0A)};
  endfunction

  // result checker with random back-pressure
  always @(posedge clk) begin
    hcdr_pkg::result_t e;
    out_ready <= steady || ($urandom_range(99) >= 20);
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d byte %0h offset %0d status %0d",
                   out_kind, out_payload_byte, out_payload_offset, out_status);
      end else begin
        e = expected_results.pop_front();
        if (out_kind !== e.kind || out_payload_byte !== e.payload_byte ||
            out_payload_offset !== e.payload_offset || out_status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0h %0d %0d, got %0d %0h %0d %0d",
                     e.kind, e.payload_byte, e.payload_offset, e.status,
                     out_kind, out_payload_byte, out_payload_offset, out_status);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // bytes, ticks and the unused op outside a download
  task automatic test_ignored_items();
    send_item(hcdr_pkg::OP_BYTE, 8'h00);
    send_item(hcdr_pkg::OP_BYTE, 8'hFF);
    send_item(hcdr_pkg::OP_TICK, 8'h55);
    send_item(OP_UNUSED, 8'hAA);
  endtask

  // shortest header timeout trips on the first tick
  task automatic test_header_timeout();
    configure(21'd64, 32'd0, 16'd1, 16'd2000);
    send_item(hcdr_pkg::OP_START, 8'h00);
    send_item(hcdr_pkg::OP_TICK, 8'h00);
  endtask

  // a minus sign on the size rejects the header
  task automatic test_negative_size();
    configure(21'd64, 32'd0, 16'd1500, 16'd2000);
    send_item(hcdr_pkg::OP_START, 8'h00);
    send_text({"MCFONT 1 -64 0", string'(8'h0A)});
  endtask

  // largest size and crc accepted, then abandoned by a new start
  task automatic test_largest_header();
    configure(21'(MAX_SIZE), hcdr_pkg::SAT32, 16'hFFFF, 16'hFFFF);
    send_item(hcdr_pkg::OP_START, 8'h00);
    send_text({"MCFONT 1 1572864 ffffffff", string'(8'h0A)});
    repeat (3) send_item(hcdr_pkg::OP_BYTE, 8'($urandom_range(255)));
    send_item(hcdr_pkg::OP_START, 8'h00);
    send_item(hcdr_pkg::OP_TICK, 8'h00);
  endtask

  // one random download of the given flavor
  task automatic run_download(input flavor_t fl);
    logic [7:0] payload[$];
    logic [31:0] crc;
    logic [15:0] hto, ito;
    string line;
    int sz, tick_pct, stop_at;
    sz = ($urandom_range(9) == 0) ? $urandom_range(64, 300) : $urandom_range(64, 72);
    crc = hcdr_pkg::SAT32;
    payload.delete();
    for (int i = 0; i < sz; i++) begin
      payload.push_back(8'($urandom_range(255)));
      crc = crc_step(crc, payload[i]);
    end
    crc = ~crc;
    if (fl == V_CRC_BAD) crc = crc ^ (32'd1 << $urandom_range(31));
    hto = (fl == V_HDR_TIMEOUT) ? 16'($urandom_range(1, 6)) : 16'($urandom_range(200, 65535));
    ito = (fl == V_PAY_TIMEOUT) ? 16'($urandom_range(1, 4)) : 16'($urandom_range(200, 65535));
    tick_pct = (fl == V_HDR_TIMEOUT || fl == V_PAY_TIMEOUT) ? 25 : 2;
    configure(21'(sz), crc, hto, ito);
    send_item(hcdr_pkg::OP_START, 8'h00);
    line = header_line(sz, crc, fl);
    for (int i = 0; i < line.len(); i++) begin
      if ($urandom_range(99) < tick_pct)
        send_item(hcdr_pkg::OP_TICK, 8'($urandom_range(255)));
      send_item(hcdr_pkg::OP_BYTE, line[i]);
    end
    if (dl_phase != hcdr_pkg::PH_PAYLOAD) begin
      send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      return;
    end
    stop_at = (fl == V_ABANDON) ? $urandom_range(1, sz - 1) : sz;
    for (int i = 0; i < stop_at && dl_phase == hcdr_pkg::PH_PAYLOAD; i++) begin
      if ($urandom_range(99) < tick_pct)
        send_item(hcdr_pkg::OP_TICK, 8'($urandom_range(255)));
      if (dl_phase == hcdr_pkg::PH_PAYLOAD) send_item(hcdr_pkg::OP_BYTE, payload[i]);
    end
    // closing transaction of any kind collects the final status of a completed download
    send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
  endtask

  task automatic test_random_downloads();
    int n;
    flavor_t fl;
    n = 0;
    while (items_sent < 950) begin
      steady = (n >= 3 && n <= 5);
      fl = ($urandom_range(9) < 4) ? V_GOOD : flavor_t'($urandom_range(V_ABANDON));
      run_download(fl);
      n++;
    end
    steady = 1'b0;
  endtask

  initial begin
    size_reg = 21'd64;
    crc_reg = 32'd0;
    hdr_limit = 16'd1500;
    idle_limit = 16'd2000;
    open_download();
    dl_phase = hcdr_pkg::PH_IDLE;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ignored_items();
    test_header_timeout();
    test_negative_size();
    test_largest_header();
    test_random_downloads();
    drain();
    repeat (10) @(posedge clk);
    if (expected_results.size() != 0) mismatches++;
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire
